/* rtl/core/rue_pkg.sv */
// Shared types and constants for the rule edge enumerator.
// Holds the configuration bundle, the request record and register indexes.
// No dependencies.
`default_nettype none

package rue_pkg;

	localparam int MASK_W    = 16;
	localparam int FCOUNT_W  = 5;
	localparam int RULE_W    = 8;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COND_SET    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COND_CLEAR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECREASE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EFFECT_SET  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EFFECT_KEEP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EFFECT_FIX  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FEAT_COUNT  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RULE_NUM    = 3'd7;

	typedef struct packed {
		logic [MASK_W-1:0]   cond_set;
		logic [MASK_W-1:0]   cond_clear;
		logic [MASK_W-1:0]   decrease;
		logic [MASK_W-1:0]   eff_set;
		logic [MASK_W-1:0]   eff_keep;
		logic [MASK_W-1:0]   eff_fixed;
		logic [FCOUNT_W-1:0] feat_count;
		logic [RULE_W-1:0]   rule_num;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic restart;
	} req_t;

endpackage

`default_nettype wire

/* rtl/core/rue_queue.sv */
// Front end: accepts request beats and buffers them in a two-entry queue.
// Uses rue_pkg for the request record handed to the engine.
`default_nettype none

module rue_queue
	import rue_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_stall,
	input  wire  restart,
	input  wire  pop,
	output req_t req
);

	logic [1:0] count_q;
	logic       wr_q;
	logic       rd_q;
	logic       ent_q [2];
	logic       push;

	assign in_stall    = (count_q == 2'd2);
	assign push        = in_valid && !in_stall;
	assign req.valid   = (count_q != 2'd0);
	assign req.restart = ent_q[rd_q];

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	// store the request flag
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= restart;
	end

endmodule

`default_nettype wire

/* rtl/core/rue_engine.sv */
// Back end: scans sources, walks the free-bit assignments and loads the result register.
// Uses rue_pkg for the configuration bundle and request record.
`default_nettype none

module rue_engine
	import rue_pkg::*;
#(
	parameter int VERTEX_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  cfg_t               cfg,
	input  req_t               req,
	output logic               pop,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [MASK_W-1:0]  source_vertex,
	output logic [MASK_W-1:0]  target_vertex,
	output logic [RULE_W-1:0]  edge_rule,
	output logic               done_res
);

	localparam int VW = (VERTEX_BITS < MASK_W) ? VERTEX_BITS : MASK_W;
	localparam int NW = $clog2(VW + 1);
	localparam int AW = $clog2(VW);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic          state_q;
	logic          run_q;
	logic [VW:0]   src_q;
	logic [VW-1:0] asg_q;
	logic          out_valid_q;
	logic          done_q;
	logic [MASK_W-1:0] src_o_q;
	logic [MASK_W-1:0] tgt_q;
	logic [RULE_W-1:0] rule_q;

	logic [NW-1:0] n_bits;
	logic [VW:0]   num_vert;
	logic [VW-1:0] vmask;
	logic [VW-1:0] need_one;
	logic [VW-1:0] need_zero;
	logic [VW-1:0] free_pos;
	logic [VW-1:0] src_v;
	logic [VW-1:0] dep;
	logic [VW-1:0] target;
	logic [AW-1:0] rank [VW];
	logic [NW-1:0] free_cnt;
	logic [VW:0]   asg_lim;
	logic          kept;
	logic          asg_ok;
	logic          asg_last;
	logic          scan_end;
	logic          hit;
	logic          can_load;
	logic          emit;

	// clamp the feature count and derive vertex masks
	assign n_bits   = (cfg.feat_count > FCOUNT_W'(VW)) ? NW'(VW) : cfg.feat_count[NW-1:0];
	assign num_vert = {{VW{1'b0}}, 1'b1} << n_bits;
	assign vmask    = num_vert[VW-1:0] - {{(VW-1){1'b0}}, 1'b1};

	assign src_v     = src_q[VW-1:0];
	assign need_one  = (cfg.cond_set[VW-1:0] | cfg.decrease[VW-1:0]) & vmask;
	assign need_zero = cfg.cond_clear[VW-1:0] & vmask;
	assign kept      = ((src_v & need_one) == need_one) && ((src_v & need_zero) == '0);

	// count of assignments is two to the number of free positions
	assign free_pos = ~cfg.eff_fixed[VW-1:0] & vmask;
	assign free_cnt = NW'($countones(free_pos));
	assign asg_lim  = {{VW{1'b0}}, 1'b1} << free_cnt;
	assign asg_ok   = ({1'b0, asg_q} < asg_lim);
	assign asg_last = (({1'b0, asg_q} + {{VW{1'b0}}, 1'b1}) >= asg_lim);

	// deposit the assignment bits into the free positions, lowest first
	always_comb begin
		for (int p = 0; p < VW; p++) begin
			rank[p] = AW'($countones(free_pos & ((VW'(1) << p) - VW'(1))));
			dep[p]  = free_pos[p] & asg_q[rank[p]];
		end
	end

	assign target = ((cfg.eff_set[VW-1:0] | (cfg.eff_keep[VW-1:0] & src_v))
		& cfg.eff_fixed[VW-1:0] & vmask) | dep;

	assign scan_end = !run_q || (src_q >= num_vert);
	assign hit      = kept && asg_ok;
	assign can_load = !out_valid_q || !out_stall;
	assign emit     = (state_q == ST_SCAN) && (scan_end || hit) && can_load;
	assign pop      = (state_q == ST_IDLE) && req.valid;

	// sequence the scan: take a request, step sources until an edge or the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_q       <= 1'b0;
			src_q       <= '0;
			asg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !emit)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						if (req.restart) begin
							src_q <= '0;
							asg_q <= '0;
							run_q <= 1'b1;
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						if (can_load) begin
							out_valid_q <= 1'b1;
							run_q       <= 1'b0;
							state_q     <= ST_IDLE;
						end
					end else if (hit) begin
						if (can_load) begin
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
							if (asg_last) begin
								src_q <= src_q + {{VW{1'b0}}, 1'b1};
								asg_q <= '0;
							end else begin
								asg_q <= asg_q + {{(VW-1){1'b0}}, 1'b1};
							end
						end
					end else begin
						src_q <= src_q + {{VW{1'b0}}, 1'b1};
						asg_q <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// load the result payload; a done beat carries zero fields
	always_ff @(posedge clk) begin
		if (emit) begin
			done_q  <= scan_end;
			src_o_q <= scan_end ? '0 : MASK_W'(src_v);
			tgt_q   <= scan_end ? '0 : MASK_W'(target);
			rule_q  <= scan_end ? '0 : cfg.rule_num;
		end
	end

	assign out_valid     = out_valid_q;
	assign done_res      = done_q;
	assign source_vertex = src_o_q;
	assign target_vertex = tgt_q;
	assign edge_rule     = rule_q;

`ifndef SYNTH
	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("result not presented after emit");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && done_q) |-> (src_o_q == '0 && tgt_q == '0 && rule_q == '0))
		else $error("done beat carries nonzero fields");

	a_scan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && !emit) |=> (state_q == ST_SCAN))
		else $error("scan left without a result");

	a_fixed_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !done_q) |->
		((tgt_q[VW-1:0] & cfg.eff_fixed[VW-1:0] & vmask) ==
		 ((cfg.eff_set[VW-1:0] | (cfg.eff_keep[VW-1:0] & src_o_q[VW-1:0]))
		  & cfg.eff_fixed[VW-1:0] & vmask)))
		else $error("fixed target bits disagree with source");
`endif

endmodule

`default_nettype wire

/* rtl/core/rule_edge_enumerator.sv */
// Top level of the rule edge enumerator: configuration registers, request queue, scan engine.
// Depends on rue_pkg, rue_queue and rue_engine.
//
//   channel  signals                                  direction  handshake
//   in       in_valid, in_stall, restart              request    valid & !stall
//   out      out_valid, out_stall, source_vertex,     result     valid & !stall
//            target_vertex, edge_rule, done_res
//   cfg      cfg_valid, cfg_ready, cfg_index,         write      valid & ready
//            cfg_data
//
// A request leaves the queue when the idle engine pops it; the engine then tests one source
// per cycle, holding only while a found edge or done beat waits on a stalled result. A kept
// source gives the edge loaded into the result register; each rejected source is stepped past.
// Reset clears queue, engine state and output valid; registers take their reset values.
// The queue takes two requests while the engine scans or waits on a stalled result.
`default_nettype none

module rule_edge_enumerator
	import rue_pkg::*;
#(
	parameter int VERTEX_BITS = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire                  restart,
	output logic                 out_valid,
	input  wire                  out_stall,
	output logic [MASK_W-1:0]    source_vertex,
	output logic [MASK_W-1:0]    target_vertex,
	output logic [RULE_W-1:0]    edge_rule,
	output logic                 done_res,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [MASK_W-1:0]    cfg_data
);

	cfg_t cfg_q;
	req_t req;
	logic pop;

	assign cfg_ready = 1'b1;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{'0, '0, '0, '0, '0, '0, FCOUNT_W'(1), '0};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COND_SET:    cfg_q.cond_set   <= cfg_data;
				REG_COND_CLEAR:  cfg_q.cond_clear <= cfg_data;
				REG_DECREASE:    cfg_q.decrease   <= cfg_data;
				REG_EFFECT_SET:  cfg_q.eff_set    <= cfg_data;
				REG_EFFECT_KEEP: cfg_q.eff_keep   <= cfg_data;
				REG_EFFECT_FIX:  cfg_q.eff_fixed  <= cfg_data;
				REG_FEAT_COUNT:  cfg_q.feat_count <= cfg_data[FCOUNT_W-1:0];
				REG_RULE_NUM:    cfg_q.rule_num   <= cfg_data[RULE_W-1:0];
				default: ;
			endcase
		end
	end

	rue_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.restart  (restart),
		.pop      (pop),
		.req      (req)
	);

	rue_engine #(
		.VERTEX_BITS (VERTEX_BITS)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.req           (req),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.source_vertex (source_vertex),
		.target_vertex (target_vertex),
		.edge_rule     (edge_rule),
		.done_res      (done_res)
	);

endmodule

`default_nettype wire
